### rtl/hill_cipher_block_modes_assert.svh
// Assertion macros used by the RTL of the block.
`ifndef HILL_CIPHER_BLOCK_MODES_ASSERT_SVH
`define HILL_CIPHER_BLOCK_MODES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HCBM_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HCBM_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HCBM_ASSERT_SAME(label, clock, rst_n, ante, cons)
`define HCBM_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

### rtl/hcbm_pkg.sv
`default_nettype none
package hcbm_pkg;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CFB = 2'd2,
		MODE_OFB = 2'd3
	} chain_mode_t;

	localparam logic [2:0] REG_ENC_ROW0   = 3'd0;
	localparam logic [2:0] REG_ENC_ROW1   = 3'd1;
	localparam logic [2:0] REG_ENC_ROW2   = 3'd2;
	localparam logic [2:0] REG_DEC_ROW0   = 3'd3;
	localparam logic [2:0] REG_DEC_ROW1   = 3'd4;
	localparam logic [2:0] REG_DEC_ROW2   = 3'd5;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd6;
	localparam logic [2:0] REG_INIT_VEC   = 3'd7;

	localparam logic [23:0] ROW0_RESET = 24'h000001;
	localparam logic [23:0] ROW1_RESET = 24'h000100;
	localparam logic [23:0] ROW2_RESET = 24'h010000;

	typedef logic [2:0][23:0] matrix_t;

	// Vector times matrix, each result byte is the low byte of the sum.
	function automatic logic [23:0] hill_mul(input logic [23:0] x, input matrix_t rows);
		logic [23:0] y;
		logic [7:0]  acc;
		logic [15:0] prod;
		for (int i = 0; i < 3; i++) begin
			acc = 8'd0;
			for (int r = 0; r < 3; r++) begin
				prod = x[8*r +: 8] * rows[r][8*i +: 8];
				acc = acc + prod[7:0];
			end
			y[8*i +: 8] = acc;
		end
		return y;
	endfunction

endpackage
`default_nettype wire

### rtl/hill_cipher_block_modes.sv
// An accepted item moves from the input register to the output register.
// One item per cycle unless the output stalls; the chaining register
// updates as an item leaves the input register; items chain with no bubble.
// Reset (arst_n low, asynchronous) empties both stages, clears the chaining
// register and loads the identity matrices, ECB encrypt and a zero IV.
`default_nettype none
`include "hill_cipher_block_modes_assert.svh"
module hill_cipher_block_modes
	import hcbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // in_byte0, in_byte1, in_byte2
	input  wire logic        s_axis_tuser,   // start_of_image
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata    // out_byte0, out_byte1, out_byte2
);

	matrix_t     enc_q;
	matrix_t     dec_q;
	chain_mode_t mode_q;
	logic        decrypt_q;
	logic [23:0] iv_q;
	logic [23:0] chain_q;

	logic        valid_s1;
	logic        sof_s1;
	logic [23:0] data_s1;
	logic        valid_s2;
	logic [23:0] out_s2;

	logic        advance;
	logic        fire_s1;
	logic [23:0] chain_cur;
	logic [23:0] mul_in;
	logic [23:0] prod;
	logic [23:0] result;
	logic [23:0] chain_next;
	logic        use_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q     <= {ROW2_RESET, ROW1_RESET, ROW0_RESET};
			dec_q     <= {ROW2_RESET, ROW1_RESET, ROW0_RESET};
			mode_q    <= MODE_ECB;
			decrypt_q <= 1'b0;
			iv_q      <= 24'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENC_ROW0: enc_q[0] <= cfg_data;
				REG_ENC_ROW1: enc_q[1] <= cfg_data;
				REG_ENC_ROW2: enc_q[2] <= cfg_data;
				REG_DEC_ROW0: dec_q[0] <= cfg_data;
				REG_DEC_ROW1: dec_q[1] <= cfg_data;
				REG_DEC_ROW2: dec_q[2] <= cfg_data;
				REG_CHAIN_MODE: begin
					mode_q    <= chain_mode_t'(cfg_data[2:1]);
					decrypt_q <= cfg_data[0];
				end
				REG_INIT_VEC: iv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance       = !valid_s2 || m_axis_tready;
	assign fire_s1       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = out_s2;

	always_comb begin
		chain_cur = sof_s1 ? iv_q : chain_q;
		use_dec   = decrypt_q && (mode_q == MODE_ECB || mode_q == MODE_CBC);
		unique case (mode_q)
			MODE_ECB: mul_in = data_s1;
			MODE_CBC: mul_in = decrypt_q ? data_s1 : (data_s1 ^ chain_cur);
			default:  mul_in = chain_cur;
		endcase
		prod = hill_mul(mul_in, use_dec ? dec_q : enc_q);
		unique case (mode_q)
			MODE_ECB: begin
				result     = prod;
				chain_next = chain_cur;
			end
			MODE_CBC: begin
				result     = decrypt_q ? (prod ^ chain_cur) : prod;
				chain_next = decrypt_q ? data_s1 : prod;
			end
			MODE_CFB: begin
				result     = prod ^ data_s1;
				chain_next = decrypt_q ? data_s1 : (prod ^ data_s1);
			end
			default: begin
				result     = prod ^ data_s1;
				chain_next = prod;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			chain_q  <= 24'd0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1) begin
				chain_q <= chain_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			sof_s1  <= s_axis_tuser;
		end
		if (fire_s1) begin
			out_s2 <= result;
		end
	end

	`HCBM_ASSERT_NEXT(a_stage_moves, clk, arst_n, fire_s1, valid_s2)
	`HCBM_ASSERT_SAME(a_stall_cause, clk, arst_n, !s_axis_tready, valid_s2 && !m_axis_tready)
	`HCBM_ASSERT_NEXT(a_ecb_chain_kept, clk, arst_n,
		fire_s1 && mode_q == MODE_ECB && !sof_s1, $stable(chain_q))
	`HCBM_ASSERT_NEXT(a_ofb_keystream, clk, arst_n,
		fire_s1 && mode_q == MODE_OFB, out_s2 == ($past(data_s1) ^ chain_q))

endmodule
`default_nettype wire
